// ===== rtl/hidrp_pkg.sv =====
package hidrp_pkg;

  localparam int MaxFieldsDefault  = 64;
  localparam int UsageDepthDefault = 16;

  localparam logic [1:0] TypeMain     = 2'd0;
  localparam logic [1:0] TypeGlobal   = 2'd1;
  localparam logic [1:0] TypeLocal    = 2'd2;
  localparam logic [1:0] TypeReserved = 2'd3;

  localparam logic [3:0] TagInput   = 4'd8;
  localparam logic [3:0] TagPage    = 4'd0;
  localparam logic [3:0] TagLmin    = 4'd1;
  localparam logic [3:0] TagLmax    = 4'd2;
  localparam logic [3:0] TagPmin    = 4'd3;
  localparam logic [3:0] TagPmax    = 4'd4;
  localparam logic [3:0] TagExp     = 4'd5;
  localparam logic [3:0] TagUnit    = 4'd6;
  localparam logic [3:0] TagSize    = 4'd7;
  localparam logic [3:0] TagId      = 4'd8;
  localparam logic [3:0] TagCount   = 4'd9;
  localparam logic [3:0] TagUsage   = 4'd0;

  // Long-item prefix: tag 15, reserved type, two data bytes.
  localparam logic [7:0] PrefixLong = 8'hFE;

  localparam logic [1:0] KindMore  = 2'd0;
  localparam logic [1:0] KindLast  = 2'd1;
  localparam logic [1:0] KindError = 2'd2;
  localparam logic [1:0] KindTrunc = 2'd3;

  // Complete item handed from the byte decoder to the executor.
  typedef struct packed {
    logic        start;
    logic [7:0]  prefix;
    logic [31:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0]  rpt_id;
    logic [15:0] page_id;
    logic [15:0] usage;
    logic [31:0] field_bit_offset;
    logic [31:0] field_bit_size;
    logic [31:0] logical_min;
    logic [31:0] logical_max;
    logic [31:0] physical_min;
    logic [31:0] physical_max;
    logic [7:0]  unit_exponent;
    logic [31:0] unit_code;
    logic [1:0]  record_kind;
  } rec_t;

endpackage

// ===== rtl/hidrp_front.sv =====
module hidrp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_byte,
  input  logic               s_start,
  output logic               item_valid,
  input  logic               item_ready,
  output hidrp_pkg::item_t   item
);

  logic [2:0]  phase;
  logic [7:0]  prefix;
  logic [31:0] data;
  logic        pend_start;
  logic        halted;
  logic [2:0]  need;
  logic        acc;
  logic [2:0]  cur_phase;
  logic [7:0]  cur_prefix;
  logic [31:0] cur_data;
  logic [2:0]  cur_need;
  logic        done;
  logic        is_long;

  // Halt is mirrored here so that no item follows a long tag until the next start.
  assign s_tready = !item_valid || item_ready;
  assign acc      = s_tvalid && s_tready;

  always_comb begin
    cur_phase  = s_start ? 3'd0 : phase;
    cur_prefix = (cur_phase == 3'd0) ? s_byte : prefix;
    cur_data   = (cur_phase == 3'd0) ? 32'd0 : data;
    if (cur_phase != 3'd0) begin
      cur_data = data | ({24'd0, s_byte} << (5'd8 * {3'd0, cur_phase[1:0] - 2'd1}));
    end
    need     = (cur_prefix[1:0] == 2'b11) ? 3'd4 : {1'b0, cur_prefix[1:0]};
    cur_need = need;
    done     = (cur_phase == 3'd0) ? (cur_prefix[1:0] == 2'b00)
                                   : ((cur_phase) >= cur_need);
    is_long  = cur_prefix == hidrp_pkg::PrefixLong;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= 3'd0;
      halted     <= 1'b0;
      item_valid <= 1'b0;
      pend_start <= 1'b0;
    end else begin
      if (item_valid && item_ready) item_valid <= 1'b0;
      if (acc) begin
        if (s_start || !halted) begin
          if (s_start) halted <= 1'b0;
          prefix <= cur_prefix;
          data   <= cur_data;
          if (done) begin
            phase      <= 3'd0;
            item_valid <= 1'b1;
            item.start <= s_start || pend_start;
            item.prefix <= cur_prefix;
            item.data  <= cur_data;
            pend_start <= 1'b0;
            if (is_long) halted <= 1'b1;
          end else begin
            phase <= cur_phase + 3'd1;
            if (s_start) pend_start <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/hidrp_back.sv =====
module hidrp_back #(
  parameter int MAX_FIELDS  = hidrp_pkg::MaxFieldsDefault,
  parameter int USAGE_DEPTH = hidrp_pkg::UsageDepthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  hidrp_pkg::item_t  item,
  output logic              m_tvalid,
  input  logic              m_tready,
  output hidrp_pkg::rec_t   rec
);

  localparam int QW = (USAGE_DEPTH > 1) ? $clog2(USAGE_DEPTH) : 1;
  localparam int CW = $clog2(USAGE_DEPTH + 1);
  localparam int FW = $clog2(MAX_FIELDS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_MUL = 4'b0010, S_EMIT = 4'b0100, S_DROP = 4'b1000
  } state_t;

  state_t state;
  logic [15:0] queue [USAGE_DEPTH];
  logic [QW-1:0] head;
  logic [CW-1:0] qcount;
  logic [15:0] page_reg;
  logic [31:0] lmin_reg, lmax_reg, pmin_reg, pmax_reg, unit_reg, size_reg, count_reg;
  logic [31:0] offset_reg, pos, product, left;
  logic [7:0]  exp_reg, id_reg;
  logic [15:0] use_reg;
  logic [FW-1:0] nleft;
  logic        emit_fld, dflt, trunc;
  logic [1:0]  typ;
  logic [3:0]  tag;
  logic [31:0] d;
  logic [QW-1:0] tail;
  logic        out_free;

  assign typ = item.prefix[3:2];
  assign tag = item.prefix[7:4];
  assign d   = item.data;
  assign out_free   = !m_tvalid || m_tready;
  assign item_ready = (state == S_IDLE) && out_free;
  assign dflt = (pmax_reg == 32'hFFFF_FFFF) || (pmin_reg == 32'hFFFF_FFFF) ||
                (pmax_reg == 32'd0 && pmin_reg == 32'd0);

  function automatic logic [QW-1:0] wrap_inc(input logic [QW-1:0] v);
    if ({1'b0, v} == (QW+1)'(USAGE_DEPTH - 1)) return '0;
    return v + QW'(1);
  endfunction

  function automatic logic [QW-1:0] wrap_add(input logic [QW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(USAGE_DEPTH)) s = s - (CW+1)'(USAGE_DEPTH);
    return QW'(s);
  endfunction

  assign tail = wrap_add(head, qcount);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; m_tvalid <= 1'b0; qcount <= '0; head <= '0;
      page_reg <= '0; lmin_reg <= '0; lmax_reg <= '0; pmin_reg <= '0; pmax_reg <= '0;
      exp_reg <= '0; unit_reg <= '0; size_reg <= '0; count_reg <= '0; id_reg <= '0;
      offset_reg <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (item_valid && out_free) begin
            if (item.start) begin
              page_reg <= '0; lmin_reg <= '0; lmax_reg <= '0; pmin_reg <= '0;
              pmax_reg <= '0; exp_reg <= '0; unit_reg <= '0; size_reg <= '0;
              count_reg <= '0; id_reg <= '0; offset_reg <= '0; qcount <= '0;
            end
            if (item.prefix == hidrp_pkg::PrefixLong) begin
              rec <= '0; rec.record_kind <= hidrp_pkg::KindError; m_tvalid <= 1'b1;
            end else if (typ == hidrp_pkg::TypeMain) begin
              if (tag == hidrp_pkg::TagInput && (d[0] || d[1])) begin
                // Work from the registers as the start item has just cleared them.
                emit_fld <= !d[0] && !item.start;
                state    <= S_MUL;
              end
            end else if (typ == hidrp_pkg::TypeGlobal) begin
              unique case (tag)
                hidrp_pkg::TagPage:  page_reg <= d[15:0];
                hidrp_pkg::TagLmin:  lmin_reg <= d;
                hidrp_pkg::TagLmax:  lmax_reg <= d;
                hidrp_pkg::TagPmin:  pmin_reg <= d;
                hidrp_pkg::TagPmax:  pmax_reg <= d;
                hidrp_pkg::TagExp:   exp_reg  <= (d >= 32'd8 && d <= 32'd15) ?
                                                 8'(d - 32'd16) : d[7:0];
                hidrp_pkg::TagUnit:  unit_reg <= d;
                hidrp_pkg::TagSize:  size_reg <= d;
                hidrp_pkg::TagId: begin
                  id_reg <= d[7:0]; offset_reg <= '0; qcount <= '0;
                end
                hidrp_pkg::TagCount: count_reg <= d;
                default: ;
              endcase
            end else if (typ == hidrp_pkg::TypeLocal) begin
              if (tag == hidrp_pkg::TagUsage &&
                  (qcount < CW'(USAGE_DEPTH) || item.start)) begin
                queue[item.start ? head : tail] <= d[15:0];
                qcount <= item.start ? CW'(1) : qcount + CW'(1);
              end
            end
          end
        end
        S_MUL: begin
          product <= 32'(size_reg * count_reg);
          pos     <= offset_reg;
          use_reg <= '0;
          trunc   <= count_reg > 32'(MAX_FIELDS);
          nleft   <= (count_reg > 32'(MAX_FIELDS)) ? FW'(MAX_FIELDS) : FW'(count_reg);
          left    <= (count_reg > 32'(MAX_FIELDS)) ? count_reg - 32'(MAX_FIELDS) : '0;
          if (emit_fld && count_reg != 32'd0) state <= S_EMIT;
          else state <= S_DROP;
          if (!emit_fld) left <= '0;
        end
        S_EMIT: begin
          if (out_free) begin
            logic [15:0] u;
            u = use_reg;
            if (qcount != '0) begin
              u = queue[head]; head <= wrap_inc(head); qcount <= qcount - CW'(1);
            end
            use_reg <= u;
            rec.rpt_id <= id_reg; rec.page_id <= page_reg; rec.usage <= u;
            rec.field_bit_offset <= pos; rec.field_bit_size <= size_reg;
            rec.logical_min <= lmin_reg; rec.logical_max <= lmax_reg;
            rec.physical_min <= dflt ? lmin_reg : pmin_reg;
            rec.physical_max <= dflt ? lmax_reg : pmax_reg;
            rec.unit_exponent <= exp_reg; rec.unit_code <= unit_reg;
            rec.record_kind <= (nleft != FW'(1)) ? hidrp_pkg::KindMore :
                               trunc ? hidrp_pkg::KindTrunc : hidrp_pkg::KindLast;
            m_tvalid <= 1'b1;
            pos   <= pos + size_reg;
            nleft <= nleft - FW'(1);
            if (nleft == FW'(1)) state <= S_DROP;
          end
        end
        S_DROP: begin
          if (left != '0) begin
            if (left >= 32'(qcount)) qcount <= '0;
            else qcount <= qcount - CW'(left);
            head <= wrap_add(head, (left >= 32'(qcount)) ? qcount : CW'(left));
          end
          offset_reg <= offset_reg + product;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/hid_report_descriptor_parser_top.sv =====
// HID report descriptor parser. Feed descriptor bytes one per request on the
// slave side, with start set on the first byte of each descriptor. Short items
// are assembled by a front decoder and passed through a one-item register to
// an executor that keeps the global state and a usage queue. The executor
// handles a completed item in its idle state, except an Input item with the
// constant or data flag, which then steps through the multiply, emit loop (one
// field record per step, at most MAX_FIELDS) and offset update states; output
// stalls hold the emit loop and the idle state.
// Input is held off while the executor is busy and the item register is full.
// A long tag produces one error record and the parser ignores bytes until start.
module hid_report_descriptor_parser_top #(
  parameter int MAX_FIELDS  = hidrp_pkg::MaxFieldsDefault,
  parameter int USAGE_DEPTH = hidrp_pkg::UsageDepthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,  // desc_byte
  input  logic         s_tuser,  // start_req
  output logic         m_tvalid,
  input  logic         m_tready,
  // report id, usage page, usage, field_bit_offset, field_bit_size,
  // logical_min, logical_max, physical_min, physical_max, unit_exponent,
  // unit_code
  output logic [271:0] m_tdata,
  output logic [1:0]   m_tuser   // record_kind
);

  logic             item_valid, item_ready;
  hidrp_pkg::item_t item;
  hidrp_pkg::rec_t  rec;

  hidrp_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_byte(s_tdata), .s_start(s_tuser),
    .item_valid, .item_ready, .item
  );

  hidrp_back #(.MAX_FIELDS(MAX_FIELDS), .USAGE_DEPTH(USAGE_DEPTH)) u_back (
    .clk, .rst, .item_valid, .item_ready, .item, .m_tvalid, .m_tready, .rec
  );

  // Pack lowest field first.
  assign m_tdata = {rec.unit_code, rec.unit_exponent, rec.physical_max,
                    rec.physical_min, rec.logical_max, rec.logical_min,
                    rec.field_bit_size, rec.field_bit_offset, rec.usage,
                    rec.page_id, rec.rpt_id};
  assign m_tuser = rec.record_kind;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int MaxFields  = hidrp_pkg::MaxFieldsDefault;
  localparam int UsageDepth = hidrp_pkg::UsageDepthDefault;

  // desc_byte in bits 7:0, start_req in bit 8
  typedef logic [8:0] desc_req_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [271:0] m_tdata;
  logic [1:0]   m_tuser;

  hid_report_descriptor_parser_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Parser state mirror
  logic [2:0]  pr_phase;
  logic [7:0]  pr_prefix;
  logic [31:0] pr_data;
  logic [15:0] pr_page;
  logic [31:0] pr_lmin, pr_lmax, pr_pmin, pr_pmax;
  logic [7:0]  pr_exp;
  logic [31:0] pr_unit, pr_size, pr_count, pr_offset;
  logic [7:0]  pr_id;
  logic [15:0] pr_usages[$];
  logic        pr_halted;

  desc_req_t         pending_reqs[$];
  hidrp_pkg::rec_t   expected_recs[$];
  int                mismatches;
  bit                stim_done;
  bit                calm;
  bit                hold_req;
  int                src_gap, snk_gap;

  task automatic clear_parser();
    pr_phase = 0; pr_prefix = 0; pr_data = 0; pr_page = 0;
    pr_lmin = 0; pr_lmax = 0; pr_pmin = 0; pr_pmax = 0; pr_exp = 0;
    pr_unit = 0; pr_size = 0; pr_count = 0; pr_offset = 0; pr_id = 0;
    pr_usages.delete(); pr_halted = 0;
  endtask

  task automatic add_req(desc_req_t q);
    pending_reqs.insert(pending_reqs.size(), q);
  endtask

  task automatic add_rec(hidrp_pkg::rec_t r);
    expected_recs.insert(expected_recs.size(), r);
  endtask

  task automatic emit_field_recs();
    logic [31:0] n, pos;
    logic [15:0] use_val;
    bit dflt;
    hidrp_pkg::rec_t r;
    n = (pr_count > MaxFields) ? MaxFields : pr_count;
    pos = pr_offset;
    use_val = 0;
    dflt = (pr_pmax == '1) || (pr_pmin == '1) || (pr_pmax == 0 && pr_pmin == 0);
    for (int i = 0; i < n; i++) begin
      if (pr_usages.size() > 0) begin
        use_val = pr_usages[0];
        pr_usages.delete(0);
      end
      r.rpt_id = pr_id; r.page_id = pr_page; r.usage = use_val;
      r.field_bit_offset = pos; r.field_bit_size = pr_size;
      r.logical_min = pr_lmin; r.logical_max = pr_lmax;
      r.physical_min = dflt ? pr_lmin : pr_pmin;
      r.physical_max = dflt ? pr_lmax : pr_pmax;
      r.unit_exponent = pr_exp; r.unit_code = pr_unit;
      if (i + 1 == n)
        r.record_kind = (pr_count > n) ? hidrp_pkg::KindTrunc : hidrp_pkg::KindLast;
      else r.record_kind = hidrp_pkg::KindMore;
      add_rec(r);
      pos += pr_size;
    end
    // dropped fields still consume usages
    for (longint k = n; k < pr_count && pr_usages.size() > 0; k++)
      pr_usages.delete(0);
    pr_offset = pr_offset + pr_size * pr_count;
  endtask

  task automatic execute_item();
    logic [1:0] typ;
    logic [3:0] tag;
    logic [31:0] d;
    hidrp_pkg::rec_t r;
    typ = pr_prefix[3:2]; tag = pr_prefix[7:4]; d = pr_data;
    if (pr_prefix == hidrp_pkg::PrefixLong) begin
      pr_halted = 1;
      r = '0;
      r.record_kind = hidrp_pkg::KindError;
      add_rec(r);
    end else if (typ == hidrp_pkg::TypeMain) begin
      if (tag == hidrp_pkg::TagInput) begin
        if (d[0]) pr_offset = pr_offset + pr_size * pr_count;
        else if (d[1]) emit_field_recs();
      end
    end else if (typ == hidrp_pkg::TypeGlobal) begin
      case (tag)
        hidrp_pkg::TagPage:  pr_page = d[15:0];
        hidrp_pkg::TagLmin:  pr_lmin = d;
        hidrp_pkg::TagLmax:  pr_lmax = d;
        hidrp_pkg::TagPmin:  pr_pmin = d;
        hidrp_pkg::TagPmax:  pr_pmax = d;
        hidrp_pkg::TagExp:   pr_exp = (d >= 8 && d <= 15) ? 8'(d - 16) : d[7:0];
        hidrp_pkg::TagUnit:  pr_unit = d;
        hidrp_pkg::TagSize:  pr_size = d;
        hidrp_pkg::TagId: begin
          pr_id = d[7:0]; pr_offset = 0; pr_usages.delete();
        end
        hidrp_pkg::TagCount: pr_count = d;
        default: ;
      endcase
    end else if (typ == hidrp_pkg::TypeLocal) begin
      if (tag == hidrp_pkg::TagUsage && pr_usages.size() < UsageDepth)
        pr_usages.insert(pr_usages.size(), d[15:0]);
    end
  endtask

  task automatic predict_byte(desc_req_t q);
    logic [31:0] need;
    if (q[8]) clear_parser();
    if (pr_halted) return;
    if (pr_phase == 0) begin
      pr_prefix = q[7:0];
      pr_data = 0;
      if (q[1:0] == 0) execute_item();
      else pr_phase = 1;
      return;
    end
    pr_data = pr_data | (32'(q[7:0]) << (8 * ((pr_phase - 1) & 3)));
    pr_phase++;
    need = (pr_prefix[1:0] == 2'd3) ? 4 : pr_prefix[1:0];
    if (pr_phase - 1 >= need) begin
      pr_phase = 0;
      execute_item();
    end
  endtask

  // Queue one short item; size code 3 means four data bytes.
  task automatic put_item(logic [7:0] prefix, logic [31:0] d, bit st = 0);
    int nb;
    nb = (prefix[1:0] == 3) ? 4 : prefix[1:0];
    add_req({st, prefix});
    for (int i = 0; i < nb; i++) add_req({1'b0, d[8*i +: 8]});
  endtask

  function automatic logic [7:0] pfx(logic [3:0] tag, logic [1:0] typ, logic [1:0] sz);
    return {tag, typ, sz};
  endfunction

  task automatic put_global(logic [3:0] tag, logic [31:0] d);
    put_item(pfx(tag, hidrp_pkg::TypeGlobal, 2'd3), d);
  endtask

  // Well-formed random report: globals, usages, then one input item.
  task automatic put_random_report();
    int nu;
    logic [1:0] sz;
    if ($urandom_range(0, 3) == 0) put_global(hidrp_pkg::TagId, $urandom);
    put_item(pfx(hidrp_pkg::TagPage, hidrp_pkg::TypeGlobal, 2'd2), $urandom);
    if ($urandom_range(0, 1)) put_global(hidrp_pkg::TagLmin, $urandom);
    if ($urandom_range(0, 1)) put_global(hidrp_pkg::TagLmax, $urandom);
    if ($urandom_range(0, 2) == 0)
      put_global(hidrp_pkg::TagPmin, ($urandom_range(0, 3) == 0) ? '1 : $urandom);
    if ($urandom_range(0, 2) == 0)
      put_global(hidrp_pkg::TagPmax, $urandom_range(0, 1) ? 0 : $urandom);
    if ($urandom_range(0, 3) == 0)
      put_item(pfx(hidrp_pkg::TagExp, hidrp_pkg::TypeGlobal, 2'd1), $urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) put_global(hidrp_pkg::TagUnit, $urandom);
    sz = 2'($urandom_range(1, 3));
    put_item(pfx(hidrp_pkg::TagSize, hidrp_pkg::TypeGlobal, sz),
             ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32));
    put_item(pfx(hidrp_pkg::TagCount, hidrp_pkg::TypeGlobal, 2'd1),
             ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80) : $urandom_range(0, 6));
    nu = $urandom_range(0, 5);
    for (int i = 0; i < nu; i++)
      put_item(pfx(hidrp_pkg::TagUsage, hidrp_pkg::TypeLocal, 2'($urandom_range(1, 3))),
               $urandom);
    put_item(pfx(hidrp_pkg::TagInput, hidrp_pkg::TypeMain, 2'd1),
             $urandom_range(0, 7) == 0 ? 8'h01 : {6'($urandom_range(0, 63)), 2'b10});
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Fill the request queue
  initial begin
    // Directed: extremes of several globals, both exponent ranges, queue overflow,
    // truncation, constant and array input, ignored items, long tag, start after it.
    put_global(hidrp_pkg::TagPage, 32'hFFFF);
    put_item(pfx(hidrp_pkg::TagLmin, hidrp_pkg::TypeGlobal, 2'd1), 8'h80);
    put_global(hidrp_pkg::TagLmax, 32'hFFFF_FFFF);
    put_item(pfx(hidrp_pkg::TagExp, hidrp_pkg::TypeGlobal, 2'd1), 8'd12);
    put_global(hidrp_pkg::TagUnit, 32'hA5A5_5A5A);
    put_item(pfx(hidrp_pkg::TagSize, hidrp_pkg::TypeGlobal, 2'd1), 8'd7);
    put_item(pfx(hidrp_pkg::TagCount, hidrp_pkg::TypeGlobal, 2'd1), 8'd70);
    for (int i = 0; i < 18; i++)
      put_item(pfx(hidrp_pkg::TagUsage, hidrp_pkg::TypeLocal, 2'd2), 16'h1000 + i);
    put_item(pfx(hidrp_pkg::TagInput, hidrp_pkg::TypeMain, 2'd1), 8'h02);
    put_item(pfx(hidrp_pkg::TagInput, hidrp_pkg::TypeMain, 2'd1), 8'h01);
    put_item(pfx(hidrp_pkg::TagInput, hidrp_pkg::TypeMain, 2'd0), 0);
    put_item(pfx(hidrp_pkg::TagInput, hidrp_pkg::TypeMain, 2'd1), 8'h00);
    put_item(pfx(4'd10, hidrp_pkg::TypeMain, 2'd1), 8'h01);
    put_item(pfx(4'd15, hidrp_pkg::TypeGlobal, 2'd1), 8'h33);
    put_item(pfx(4'd3, hidrp_pkg::TypeReserved, 2'd1), 8'h44);
    put_global(hidrp_pkg::TagPmin, 32'h8000_0000);
    put_global(hidrp_pkg::TagPmax, 32'h7FFF_FFFF);
    put_item(pfx(hidrp_pkg::TagExp, hidrp_pkg::TypeGlobal, 2'd1), 8'hFF);
    put_item(pfx(hidrp_pkg::TagId, hidrp_pkg::TypeGlobal, 2'd1), 8'hFF);
    put_item(pfx(hidrp_pkg::TagCount, hidrp_pkg::TypeGlobal, 2'd1), 8'd3);
    put_item(pfx(hidrp_pkg::TagInput, hidrp_pkg::TypeMain, 2'd1), 8'h02);
    put_item(pfx(hidrp_pkg::TagCount, hidrp_pkg::TypeGlobal, 2'd1), 8'd0);
    put_item(pfx(hidrp_pkg::TagInput, hidrp_pkg::TypeMain, 2'd1), 8'h02);
    add_req({1'b0, hidrp_pkg::PrefixLong});
    add_req({1'b0, 8'h12});
    add_req({1'b0, 8'h34});
    add_req({1'b0, 8'h81});
    add_req({1'b0, 8'h02});
    put_item(pfx(hidrp_pkg::TagUsage, hidrp_pkg::TypeLocal, 2'd3), 32'h1234_5678, 1);
    put_item(pfx(hidrp_pkg::TagCount, hidrp_pkg::TypeGlobal, 2'd3), 32'h0000_0101);
    put_item(pfx(hidrp_pkg::TagPage, hidrp_pkg::TypeGlobal, 2'd3), 32'h0000_00FF);
    put_item(pfx(hidrp_pkg::TagSize, hidrp_pkg::TypeGlobal, 2'd3), 32'hFFFF_FFFF);
    put_item(pfx(hidrp_pkg::TagInput, hidrp_pkg::TypeMain, 2'd1), 8'h02);
    put_item(pfx(hidrp_pkg::TagLmin, hidrp_pkg::TypeGlobal, 2'd3), 32'h0000_0001, 1);
    // Random: mostly well-formed reports, some noise and stray starts
    while (pending_reqs.size() < 320) begin
      if ($urandom_range(0, 9) == 0)
        add_req({1'($urandom_range(0, 3) == 0), 8'($urandom)});
      else if ($urandom_range(0, 39) == 0)
        put_item(pfx(hidrp_pkg::TagLmin, hidrp_pkg::TypeGlobal, 2'd1), $urandom, 1);
      else
        put_random_report();
    end
    put_item(pfx(hidrp_pkg::TagCount, hidrp_pkg::TypeGlobal, 2'd0), 0, 1);
    stim_done = 1;
  end

  // Sender: idles in random bursts, then runs flat out near the end
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
      s_tdata  <= 0;
      s_tuser  <= 0;
      src_gap  <= 0;
    end else begin
      if (s_tvalid && s_tready) predict_byte({s_tuser, s_tdata});
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap  <= src_gap - 1;
          s_tvalid <= 0;
        end else if (pending_reqs.size() > 0) begin
          desc_req_t q;
          q = pending_reqs[0];
          pending_reqs.delete(0);
          s_tvalid <= 1;
          s_tdata  <= q[7:0];
          s_tuser  <= q[8];
          if (!calm && $urandom_range(0, 15) == 0) src_gap <= $urandom_range(1, 10);
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // Long hold-off on the receiver, counted here while the sender keeps offering bytes
  initial begin
    hold_req = 0;
    @(negedge rst);
    repeat (20) @(posedge clk);
    hold_req <= 1;
    repeat (400) @(posedge clk);
    hold_req <= 0;
  end

  // Receiver: random stall bursts plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
      snk_gap  <= 0;
    end else begin
      if (hold_req) begin
        m_tready <= 0;
      end else if (snk_gap > 0) begin
        snk_gap  <= snk_gap - 1;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
        if (!calm && $urandom_range(0, 11) == 0) snk_gap <= $urandom_range(1, 10);
      end
    end
  end

  // Check every accepted record against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      hidrp_pkg::rec_t got, want;
      got.rpt_id           = m_tdata[7:0];
      got.page_id          = m_tdata[23:8];
      got.usage            = m_tdata[39:24];
      got.field_bit_offset = m_tdata[71:40];
      got.field_bit_size   = m_tdata[103:72];
      got.logical_min      = m_tdata[135:104];
      got.logical_max      = m_tdata[167:136];
      got.physical_min     = m_tdata[199:168];
      got.physical_max     = m_tdata[231:200];
      got.unit_exponent    = m_tdata[239:232];
      got.unit_code        = m_tdata[271:240];
      got.record_kind      = m_tuser;
      if (expected_recs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected record %h", got);
      end else begin
        want = expected_recs[0];
        expected_recs.delete(0);
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("record mismatch: expected %h got %h", want, got);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    mismatches = 0;
    calm       = 0;
    clear_parser();
    rst = 1;
    repeat (8) @(posedge clk);
    rst <= 0;
    wait (stim_done);
    wait (pending_reqs.size() < 60);
    calm = 1;
    wait (pending_reqs.size() == 0 && !s_tvalid);
    wait (expected_recs.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_recs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hidrp_pkg.sv
rtl/hidrp_front.sv
rtl/hidrp_back.sv
rtl/hid_report_descriptor_parser_top.sv
tb/testbench.sv
